// ----- rtl/lca_pkg.sv -----
package lca_pkg;

   // Default structure sizes
   localparam int DATA_BITS_DEFAULT    = 24;
   localparam int COUNTER_BITS_DEFAULT = 20;

   // Register field widths
   localparam int SCALE_W    = 16;
   localparam int LIMIT_W    = 20;
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_DIVISOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 2'd2;

   // Register reset values
   localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd421;
   localparam logic [LIMIT_W-1:0] WAIT_RESET   = 20'd1000000;
   localparam logic [LIMIT_W-1:0] PERIOD_RESET = 20'd1000000;

   // Input stream byte width
   localparam int REQ_DATA_W = 8;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear_shift;
      logic shift_en;
      logic shift_bit;
      logic finish;
      logic capture_tare;
      logic div_start;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic div_busy;
      logic div_done;
   } status_type;

   // Per-tick flags carried with each result
   typedef struct packed {
      logic halted;
      logic timed_out;
      logic tare_captured;
      logic reading_done;
      logic clock_level;
   } flags_type;

endpackage

// ----- rtl/load_cell_adc_reader_with_tare_core.sv -----
// Each accepted tick's result is registered and shown in the next cycle,
// but for the tick that completes a weight reading, whose result waits for the
// bit-serial restoring divider (one quotient bit a cycle, then the sign fix).
// Throughput: one tick a cycle unless a divide runs or a stalled result is held.
// Reset: synchronous, active high; all but the divider working registers reset.
module load_cell_adc_reader_with_tare_core #(
   parameter int DATA_BITS    = lca_pkg::DATA_BITS_DEFAULT,
   parameter int COUNTER_BITS = lca_pkg::COUNTER_BITS_DEFAULT,
   parameter int RSP_DATA_W   = ((2 * DATA_BITS + 6 + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [0] data_level
   input  logic [lca_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] clock_level, [1] reading_done, [2] tare_captured, raw_value,
   // net_weight, timed_out, halted, zero padding
   output logic [RSP_DATA_W-1:0]            rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lca_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lca_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic [lca_pkg::SCALE_W-1:0] scale_ff;
   logic [lca_pkg::LIMIT_W-1:0] wait_limit_ff;
   logic [lca_pkg::LIMIT_W-1:0] period_ff;
   lca_pkg::cmd_type            cmd;
   lca_pkg::status_type         sts;
   lca_pkg::flags_type          flags;
   logic [DATA_BITS-1:0]        raw_value;
   logic signed [DATA_BITS:0]   net_weight;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= lca_pkg::SCALE_RESET;
         wait_limit_ff <= lca_pkg::WAIT_RESET;
         period_ff     <= lca_pkg::PERIOD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            lca_pkg::CSR_SCALE_DIVISOR: scale_ff      <= csr_data[lca_pkg::SCALE_W-1:0];
            lca_pkg::CSR_WAIT_LIMIT:    wait_limit_ff <= csr_data[lca_pkg::LIMIT_W-1:0];
            lca_pkg::CSR_SAMPLE_PERIOD: period_ff     <= csr_data[lca_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   lca_ctrl #(
      .DATA_BITS    (DATA_BITS),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .data_level     (req_tdata[0]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .cfg_wait_limit (wait_limit_ff),
      .cfg_period     (period_ff),
      .cmd            (cmd),
      .sts            (sts),
      .flags          (flags)
   );

   lca_dp #(
      .DATA_BITS (DATA_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg_scale  (scale_ff),
      .sts        (sts),
      .raw_value  (raw_value),
      .net_weight (net_weight)
   );

   // Pack the result fields, last listed field lowest
   assign rsp_tdata = RSP_DATA_W'({flags.halted, flags.timed_out, net_weight, raw_value,
                                   flags.tare_captured, flags.reading_done,
                                   flags.clock_level});

endmodule

// ----- rtl/lca_ctrl.sv -----
module lca_ctrl #(
   parameter int DATA_BITS    = lca_pkg::DATA_BITS_DEFAULT,
   parameter int COUNTER_BITS = lca_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         data_level,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [lca_pkg::LIMIT_W-1:0]  cfg_wait_limit,
   input  logic [lca_pkg::LIMIT_W-1:0]  cfg_period,
   output lca_pkg::cmd_type             cmd,
   input  lca_pkg::status_type          sts,
   output lca_pkg::flags_type           flags
);

   localparam int BI_W  = $clog2(DATA_BITS + 1);
   localparam int CMP_W = (COUNTER_BITS > lca_pkg::LIMIT_W) ? COUNTER_BITS : lca_pkg::LIMIT_W;

   // Phase codes
   localparam logic [2:0] PH_WAIT   = 3'd0;
   localparam logic [2:0] PH_HIGH   = 3'd1;
   localparam logic [2:0] PH_LOW    = 3'd2;
   localparam logic [2:0] PH_FINISH = 3'd3;
   localparam logic [2:0] PH_IDLE   = 3'd4;
   localparam logic [2:0] PH_HALT   = 3'd5;

   logic [2:0]              phase_ff, phase_in;
   logic [BI_W-1:0]         bit_index_ff, bit_index_in;
   logic [COUNTER_BITS-1:0] wait_cnt_ff, wait_cnt_in;
   logic [COUNTER_BITS-1:0] period_cnt_ff, period_cnt_in;
   logic                    tare_valid_ff, tare_valid_in;
   logic                    stopped_ff, stopped_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lca_pkg::flags_type      flags_ff, flags_in;
   logic                    accept;
   logic                    load_rsp;
   logic [COUNTER_BITS-1:0] wait_next;
   logic [COUNTER_BITS-1:0] period_next;

   // Take a tick only when no divide runs and the result slot frees up
   assign req_tready = ~sts.div_busy & (~rsp_valid_ff | rsp_tready);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign flags      = flags_ff;

   assign wait_next   = wait_cnt_ff + 1'b1;
   assign period_next = period_cnt_ff + 1'b1;

   // Advance the phase sequencer by one tick
   always_comb begin
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      wait_cnt_in   = wait_cnt_ff;
      period_cnt_in = period_cnt_ff;
      tare_valid_in = tare_valid_ff;
      stopped_in    = stopped_ff;
      flags_in      = flags_ff;
      cmd           = '0;
      load_rsp      = 1'b0;

      if (accept) begin
         flags_in = '0;
         load_rsp = 1'b1;
         case (phase_ff)
            PH_WAIT: begin
               if (!data_level) begin
                  bit_index_in    = '0;
                  cmd.clear_shift = 1'b1;
                  phase_in        = PH_HIGH;
               end else begin
                  wait_cnt_in = wait_next;
                  if (CMP_W'(wait_next) >= CMP_W'(cfg_wait_limit)) begin
                     flags_in.timed_out = 1'b1;
                     stopped_in         = 1'b1;
                     phase_in           = PH_HALT;
                  end
               end
            end
            PH_HIGH: begin
               cmd.shift_en         = (bit_index_ff != '0);
               cmd.shift_bit        = data_level;
               flags_in.clock_level = 1'b1;
               phase_in = (bit_index_ff >= BI_W'(DATA_BITS)) ? PH_FINISH : PH_LOW;
            end
            PH_LOW: begin
               bit_index_in = bit_index_ff + 1'b1;
               phase_in     = PH_HIGH;
            end
            PH_FINISH: begin
               cmd.finish = 1'b1;
               if (!tare_valid_ff) begin
                  cmd.capture_tare       = 1'b1;
                  tare_valid_in          = 1'b1;
                  flags_in.tare_captured = 1'b1;
               end else begin
                  // Hold the result until the divider finishes
                  cmd.div_start         = 1'b1;
                  flags_in.reading_done = 1'b1;
                  load_rsp              = 1'b0;
               end
               period_cnt_in = '0;
               phase_in      = PH_IDLE;
            end
            PH_IDLE: begin
               period_cnt_in = period_next;
               if (CMP_W'(period_next) >= CMP_W'(cfg_period)) begin
                  wait_cnt_in = '0;
                  phase_in    = PH_WAIT;
               end
            end
            default: begin
               stopped_in = 1'b1;
               phase_in   = PH_HALT;
            end
         endcase
         flags_in.halted = stopped_in;
      end

      // Release the weight result once the quotient is ready
      if (sts.div_done) begin
         load_rsp = 1'b1;
      end

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         bit_index_ff  <= '0;
         wait_cnt_ff   <= '0;
         period_cnt_ff <= '0;
         tare_valid_ff <= 1'b0;
         stopped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         flags_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         bit_index_ff  <= bit_index_in;
         wait_cnt_ff   <= wait_cnt_in;
         period_cnt_ff <= period_cnt_in;
         tare_valid_ff <= tare_valid_in;
         stopped_ff    <= stopped_in;
         rsp_valid_ff  <= rsp_valid_in;
         flags_ff      <= flags_in;
      end
   end

endmodule

// ----- rtl/lca_dp.sv -----
module lca_dp #(
   parameter int DATA_BITS = lca_pkg::DATA_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lca_pkg::cmd_type            cmd,
   input  logic [lca_pkg::SCALE_W-1:0] cfg_scale,
   output lca_pkg::status_type         sts,
   output logic [DATA_BITS-1:0]        raw_value,
   output logic signed [DATA_BITS:0]   net_weight
);

   localparam int SW    = lca_pkg::SCALE_W;
   localparam int CNT_W = $clog2(DATA_BITS + 1);
   localparam logic [DATA_BITS-1:0] TOP_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

   logic [DATA_BITS-1:0] shift_ff;
   logic [DATA_BITS-1:0] tare_ff;
   logic [DATA_BITS-1:0] raw_ff;
   logic [DATA_BITS:0]   weight_ff;
   logic                 busy_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 neg_ff;
   logic [SW-1:0]        divisor_ff;
   logic [SW-1:0]        rem_ff;
   logic [DATA_BITS-1:0] quo_ff;

   logic [DATA_BITS-1:0] raw_in;
   logic                 neg_in;
   logic [DATA_BITS-1:0] mag_in;
   logic [SW:0]          trial;
   logic [SW:0]          diff;
   logic                 fits;
   logic                 last;
   logic [DATA_BITS:0]   quo_ext;

   // Flip the top bit of the captured word into offset binary
   assign raw_in = shift_ff ^ TOP_BIT;
   assign neg_in = raw_in < tare_ff;
   assign mag_in = neg_in ? (tare_ff - raw_in) : (raw_in - tare_ff);

   // One restoring divide step per cycle
   assign trial   = {rem_ff, quo_ff[DATA_BITS-1]};
   assign diff    = trial - {1'b0, divisor_ff};
   assign fits    = trial >= {1'b0, divisor_ff};
   assign last    = busy_ff & (cnt_ff == CNT_W'(DATA_BITS));
   assign quo_ext = {1'b0, quo_ff};

   assign sts.div_busy = busy_ff;
   assign sts.div_done = last;
   assign raw_value    = raw_ff;
   assign net_weight   = weight_ff;

   // Reading state
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= '0;
         tare_ff   <= '0;
         raw_ff    <= '0;
         weight_ff <= '0;
         busy_ff   <= 1'b0;
      end else begin
         if (cmd.clear_shift) begin
            shift_ff <= '0;
         end else if (cmd.shift_en) begin
            shift_ff <= {shift_ff[DATA_BITS-2:0], cmd.shift_bit};
         end
         if (cmd.finish) begin
            raw_ff <= raw_in;
         end
         if (cmd.capture_tare) begin
            tare_ff <= raw_in;
         end
         if (cmd.div_start) begin
            busy_ff <= 1'b1;
         end else if (last) begin
            busy_ff   <= 1'b0;
            weight_ff <= neg_ff ? (~quo_ext + 1'b1) : quo_ext;
         end
      end
   end

   // Divider working registers
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff     <= neg_in;
         quo_ff     <= mag_in;
         rem_ff     <= '0;
         cnt_ff     <= '0;
         divisor_ff <= (cfg_scale == '0) ? SW'(1) : cfg_scale;
      end else if (busy_ff && !last) begin
         rem_ff <= fits ? diff[SW-1:0] : trial[SW-1:0];
         quo_ff <= {quo_ff[DATA_BITS-2:0], fits};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

endmodule

// ----- rtl/lca_checker.sv -----
module lca_checker #(
   parameter int DATA_BITS  = lca_pkg::DATA_BITS_DEFAULT,
   parameter int RSP_DATA_W = ((2 * DATA_BITS + 6 + 7) / 8) * 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int TOUT_POS = 2 * DATA_BITS + 4;
   localparam int HALT_POS = 2 * DATA_BITS + 5;

   logic xfer;
   assign xfer = rsp_tvalid & rsp_tready;

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // A timeout halts the block on the same tick
   a_tout_halt: assert property (@(posedge clock) disable iff (reset)
      xfer && rsp_tdata[TOUT_POS] |-> rsp_tdata[HALT_POS])
      else $error("timeout without halt");

   // A halted block drives the clock low and finishes nothing
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      xfer && rsp_tdata[HALT_POS] |-> !rsp_tdata[0] && !rsp_tdata[1] && !rsp_tdata[2])
      else $error("activity while halted");

   // Tare capture and weight completion never share a tick
   a_done_tare: assert property (@(posedge clock) disable iff (reset)
      xfer |-> !(rsp_tdata[1] && rsp_tdata[2]))
      else $error("tare and weight on one tick");

endmodule

bind load_cell_adc_reader_with_tare_core lca_checker #(
   .DATA_BITS  (DATA_BITS),
   .RSP_DATA_W (RSP_DATA_W)
) u_lca_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/load_cell_adc_reader_with_tare_core_tb.sv -----
module load_cell_adc_reader_with_tare_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_BITS  = lca_pkg::DATA_BITS_DEFAULT;
   localparam int SCALE_W    = lca_pkg::SCALE_W;
   localparam int LIMIT_W    = lca_pkg::LIMIT_W;
   localparam int CSR_IDX_W  = lca_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = lca_pkg::CSR_DATA_W;
   localparam int REQ_DATA_W = lca_pkg::REQ_DATA_W;
   localparam int RSP_W      = ((2 * DATA_BITS + 6 + 7) / 8) * 8;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic [SCALE_W-1:0]   SCALE_MAX    = '1;
   localparam logic [LIMIT_W-1:0]   LIMIT_MAX    = '1;
   localparam logic [DATA_BITS-1:0] SIGN_FLIP    = {1'b1, {(DATA_BITS-1){1'b0}}};

   localparam int RANDOM_PHASES   = 12;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HALTED_TICKS    = 20;
   localparam int SETTLE_CYCLES   = DATA_BITS + 4;
   localparam int WATCHDOG_LIMIT  = 5000;

   typedef enum logic [2:0] {
      RD_WAIT, RD_HIGH, RD_LOW, RD_FINISH, RD_IDLE, RD_HALT
   } rd_phase_type;

   // one result transfer, lowest bit last
   typedef struct packed {
      logic [RSP_W-2*DATA_BITS-7:0] pad;
      logic                         halted;
      logic                         timed_out;
      logic [DATA_BITS:0]           net_weight;
      logic [DATA_BITS-1:0]         raw_value;
      logic                         tare_captured;
      logic                         reading_done;
      logic                         clock_level;
   } readout_type;

   typedef struct packed {
      rd_phase_type         phase;
      logic [5:0]           bit_index;
      logic [DATA_BITS-1:0] shift_reg;
      logic [LIMIT_W-1:0]   ready_count;
      logic [LIMIT_W-1:0]   idle_count;
      logic [DATA_BITS-1:0] tare;
      logic [DATA_BITS-1:0] last_raw;
      logic                 tare_held;
      logic                 stopped;
      logic [DATA_BITS:0]   weight;
      logic [SCALE_W-1:0]   scale;
      logic [LIMIT_W-1:0]   ready_limit;
      logic [LIMIT_W-1:0]   period;
   } reader_state_type;

   // a tick to send, with a hand-written result where one is obvious
   typedef struct packed {
      logic        lvl;
      logic        typed;
      readout_type rsp;
   } tick_row_type;

   localparam readout_type RSP_QUIET      = '0;
   localparam readout_type RSP_CLOCK_HIGH = readout_type'(RSP_W'(1));

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_W-1:0]        rsp_tdata;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   reader_state_type reader_now;
   readout_type      readouts_due[$];
   tick_row_type     tick_plan[$];
   tick_row_type     shown_row = '0;
   tick_row_type     directed_rows[24];
   int               fault_count = 0;
   int               quiet_cycles = 0;
   bit               idle_on = 1'b1;
   bit               stall_on = 1'b1;
   bit               hold_off_req = 1'b0;

   load_cell_adc_reader_with_tare_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the reader by one tick and return what it shows on that tick
   function automatic readout_type advance_tick(inout reader_state_type s, input logic lvl);
      readout_type        r;
      logic [SCALE_W-1:0] divisor;
      logic [DATA_BITS:0] quotient;
      r = '0;
      case (s.phase)
         RD_WAIT: begin
            if (!lvl) begin
               s.bit_index = '0;
               s.shift_reg = '0;
               s.phase     = RD_HIGH;
            end else begin
               s.ready_count = s.ready_count + 1'b1;
               if (s.ready_count >= s.ready_limit) begin
                  r.timed_out = 1'b1;
                  s.stopped   = 1'b1;
                  s.phase     = RD_HALT;
               end
            end
         end
         RD_HIGH: begin
            if (s.bit_index != '0) s.shift_reg = {s.shift_reg[DATA_BITS-2:0], lvl};
            r.clock_level = 1'b1;
            s.phase = (s.bit_index >= DATA_BITS) ? RD_FINISH : RD_LOW;
         end
         RD_LOW: begin
            s.bit_index = s.bit_index + 1'b1;
            s.phase     = RD_HIGH;
         end
         RD_FINISH: begin
            s.last_raw = s.shift_reg ^ SIGN_FLIP;
            if (!s.tare_held) begin
               s.tare          = s.last_raw;
               s.tare_held     = 1'b1;
               r.tare_captured = 1'b1;
            end else begin
               // a zero divisor counts as one
               divisor = (s.scale == '0) ? SCALE_W'(1) : s.scale;
               if (s.last_raw < s.tare) begin
                  quotient = {1'b0, (s.tare - s.last_raw) / DATA_BITS'(divisor)};
                  s.weight = -quotient;
               end else begin
                  quotient = {1'b0, (s.last_raw - s.tare) / DATA_BITS'(divisor)};
                  s.weight = quotient;
               end
               r.reading_done = 1'b1;
            end
            s.idle_count = '0;
            s.phase      = RD_IDLE;
         end
         RD_IDLE: begin
            s.idle_count = s.idle_count + 1'b1;
            if (s.idle_count >= s.period) begin
               s.ready_count = '0;
               s.phase       = RD_WAIT;
            end
         end
         default: begin
            s.stopped = 1'b1;
            s.phase   = RD_HALT;
         end
      endcase
      r.raw_value  = s.last_raw;
      r.net_weight = s.weight;
      r.halted     = s.stopped;
      return r;
   endfunction

   // Pick the bit pattern that the next reading shifts in, weighted to the extremes and the tare
   function automatic logic [DATA_BITS-1:0] pick_target(input reader_state_type s);
      logic [DATA_BITS-1:0] raw;
      case ($urandom_range(0, 11))
         0:       raw = '0;
         1:       raw = '1;
         2:       raw = SIGN_FLIP;
         3:       raw = ~SIGN_FLIP;
         4, 5:    raw = s.tare;
         6:       raw = s.tare + DATA_BITS'($urandom_range(0, 600)) - DATA_BITS'(300);
         default: raw = DATA_BITS'($urandom);
      endcase
      return raw ^ SIGN_FLIP;
   endfunction

   // Choose the data pin level for the next tick; keep clear of the timeout unless wanted
   function automatic logic choose_level(input reader_state_type s,
                                         input logic [DATA_BITS-1:0] target,
                                         input bit want_timeout);
      case (s.phase)
         RD_WAIT: begin
            if (want_timeout) return 1'b1;
            if (LIMIT_W'(s.ready_count + 1'b1) >= s.ready_limit) return 1'b0;
            return ($urandom_range(0, 3) != 0);
         end
         RD_HIGH: begin
            if (s.bit_index == '0) return 1'($urandom_range(0, 1));
            return target[DATA_BITS - s.bit_index];
         end
         default: return 1'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic report_fault(input string msg);
      fault_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_readout(input readout_type want);
      readout_type got;
      got = readout_type'(rsp_tdata);
      if (got.clock_level !== want.clock_level)
         report_fault($sformatf("clock_level got %0d want %0d",
                                got.clock_level, want.clock_level));
      if (got.reading_done !== want.reading_done)
         report_fault($sformatf("reading_done got %0d want %0d",
                                got.reading_done, want.reading_done));
      if (got.tare_captured !== want.tare_captured)
         report_fault($sformatf("tare_captured got %0d want %0d",
                                got.tare_captured, want.tare_captured));
      if (got.raw_value !== want.raw_value)
         report_fault($sformatf("raw_value got %h want %h", got.raw_value, want.raw_value));
      if (got.net_weight !== want.net_weight)
         report_fault($sformatf("net_weight got %h want %h",
                                got.net_weight, want.net_weight));
      if (got.timed_out !== want.timed_out)
         report_fault($sformatf("timed_out got %0d want %0d", got.timed_out, want.timed_out));
      if (got.halted !== want.halted)
         report_fault($sformatf("halted got %0d want %0d", got.halted, want.halted));
   endtask

   // Fill the tick plan by running a copy of the reader ahead of the block
   task automatic plan_ticks(input int count, input bit finale);
      reader_state_type     plan;
      readout_type          r;
      logic                 lvl;
      logic [DATA_BITS-1:0] target;
      int                   closing;
      bit                   read_seen;
      plan      = reader_now;
      target    = pick_target(plan);
      closing   = 0;
      read_seen = 1'b0;
      tick_plan.delete();
      while (finale ? (closing < HALTED_TICKS && tick_plan.size() < 2000)
                    : tick_plan.size() < count) begin
         lvl = choose_level(plan, target, finale && read_seen);
         if (plan.phase == RD_WAIT && !lvl) target = pick_target(plan);
         r = advance_tick(plan, lvl);
         read_seen |= r.reading_done | r.tare_captured;
         if (plan.stopped) closing++;
         tick_plan.push_back('{lvl: lvl, typed: 1'b0, rsp: RSP_QUIET});
      end
   endtask

   // Offer every planned tick, with occasional idle bursts between transfers while idle_on is set
   task automatic send_ticks();
      foreach (tick_plan[i]) begin
         if (idle_on && $urandom_range(0, 7) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= REQ_DATA_W'(tick_plan[i].lvl);
         shown_row  <= tick_plan[i];
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] scale_word,
                                 input logic [CSR_DATA_W-1:0] limit_word,
                                 input logic [CSR_DATA_W-1:0] period_word,
                                 input bit poke_unmapped);
      logic [CSR_IDX_W-1:0]  regs[4];
      logic [CSR_DATA_W-1:0] words[4];
      regs  = '{lca_pkg::CSR_SCALE_DIVISOR, lca_pkg::CSR_WAIT_LIMIT,
                lca_pkg::CSR_SAMPLE_PERIOD, CSR_UNMAPPED};
      words = '{scale_word, limit_word, period_word, CSR_DATA_W'($urandom)};
      for (int k = 0; k < (poke_unmapped ? 4 : 3); k++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[k];
         csr_data  <= words[k];
         do @(posedge clock); while (!csr_ready);
         case (regs[k])
            lca_pkg::CSR_SCALE_DIVISOR: reader_now.scale       = words[k][SCALE_W-1:0];
            lca_pkg::CSR_WAIT_LIMIT:    reader_now.ready_limit = words[k][LIMIT_W-1:0];
            lca_pkg::CSR_SAMPLE_PERIOD: reader_now.period      = words[k][LIMIT_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Hold until every expected result has come back, then let the block go quiet
   task automatic settle();
      while (readouts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Predict on each accepted tick, check each accepted result
   always @(posedge clock) begin
      readout_type due;
      if (!reset && req_tvalid && req_tready) begin
         due = advance_tick(reader_now, req_tdata[0]);
         if (shown_row.typed) due = shown_row.rsp;
         readouts_due.push_back(due);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (readouts_due.size() == 0) report_fault("result transfer with nothing expected");
         else check_readout(readouts_due.pop_front());
      end
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Abort when no transfer of any kind has happened for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] scale_w;
      logic [CSR_DATA_W-1:0] limit_w;
      logic [CSR_DATA_W-1:0] period_w;
      int                    count;

      reader_now             = '0;
      reader_now.phase       = RD_WAIT;
      reader_now.scale       = lca_pkg::SCALE_RESET;
      reader_now.ready_limit = lca_pkg::WAIT_RESET;
      reader_now.period      = lca_pkg::PERIOD_RESET;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle wait ticks, the start of a reading, then a run of bits
      directed_rows = '{
         '{1'b1, 1'b1, RSP_QUIET}, '{1'b1, 1'b1, RSP_QUIET}, '{1'b1, 1'b1, RSP_QUIET},
         '{1'b0, 1'b1, RSP_QUIET}, '{1'b1, 1'b1, RSP_CLOCK_HIGH}, '{1'b0, 1'b1, RSP_QUIET},
         '{1'b1, 1'b0, RSP_QUIET}, '{1'b1, 1'b0, RSP_QUIET}, '{1'b0, 1'b0, RSP_QUIET},
         '{1'b1, 1'b0, RSP_QUIET}, '{1'b0, 1'b0, RSP_QUIET}, '{1'b0, 1'b0, RSP_QUIET},
         '{1'b1, 1'b0, RSP_QUIET}, '{1'b0, 1'b0, RSP_QUIET}, '{1'b1, 1'b0, RSP_QUIET},
         '{1'b1, 1'b0, RSP_QUIET}, '{1'b1, 1'b0, RSP_QUIET}, '{1'b0, 1'b0, RSP_QUIET},
         '{1'b0, 1'b0, RSP_QUIET}, '{1'b0, 1'b0, RSP_QUIET}, '{1'b1, 1'b0, RSP_QUIET},
         '{1'b0, 1'b0, RSP_QUIET}, '{1'b1, 1'b0, RSP_QUIET}, '{1'b1, 1'b0, RSP_QUIET}
      };
      tick_plan.delete();
      foreach (directed_rows[i]) tick_plan.push_back(directed_rows[i]);
      send_ticks();
      settle();

      // Random phases, each under its own register settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         count = $urandom_range(110, 140);
         case (p)
            0: begin
               scale_w  = '0;
               limit_w  = LIMIT_MAX;
               period_w = '0;
            end
            1: begin
               scale_w  = CSR_DATA_W'(SCALE_MAX);
               limit_w  = CSR_DATA_W'(1);
               period_w = CSR_DATA_W'(1);
            end
            2: begin
               // longest period: stay in the idle count for a short while only
               scale_w  = CSR_DATA_W'(1);
               limit_w  = LIMIT_MAX;
               period_w = LIMIT_MAX;
               count    = 20;
            end
            3: begin
               scale_w  = CSR_DATA_W'(lca_pkg::SCALE_RESET);
               limit_w  = lca_pkg::WAIT_RESET;
               period_w = CSR_DATA_W'($urandom_range(0, 40));
            end
            default: begin
               scale_w  = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom_range(1, 8))
                                                      : CSR_DATA_W'($urandom);
               limit_w  = ($urandom_range(0, 1) == 0) ? CSR_DATA_W'($urandom_range(1, 12))
                                                      : CSR_DATA_W'($urandom_range(13,
                                                            (1 << LIMIT_W) - 1));
               period_w = CSR_DATA_W'($urandom_range(0, 40));
            end
         endcase
         apply_settings(scale_w, limit_w, period_w, p == 4 || $urandom_range(0, 3) == 0);
         idle_on  = $urandom_range(0, 3) != 0;
         stall_on = $urandom_range(0, 3) != 0;
         plan_ticks(count, 1'b0);
         if (p == 3) hold_off_req = 1'b1;
         send_ticks();
         settle();
      end

      // Closing part: no idling, zero wait limit, one reading then a timeout and halt
      idle_on  = 1'b0;
      stall_on = 1'b0;
      apply_settings(CSR_DATA_W'($urandom_range(1, 5000)), '0,
                     CSR_DATA_W'($urandom_range(0, 3)), 1'b0);
      plan_ticks(0, 1'b1);
      send_ticks();
      settle();

      if (readouts_due.size() != 0) report_fault("results still expected at the end");
      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/lca_pkg.sv
rtl/lca_ctrl.sv
rtl/lca_dp.sv
rtl/load_cell_adc_reader_with_tare_core.sv
rtl/lca_checker.sv
test/load_cell_adc_reader_with_tare_core_tb.sv
